/* hw/rtl/dofe_pkg.sv */
// Shared types and constants for the DHCP options field extractor.
package dofe_pkg;

  // Magic cookie bytes 99.130.83.99
  localparam logic [7:0] COOKIE_B0 = 8'd99;
  localparam logic [7:0] COOKIE_B1 = 8'd130;
  localparam logic [7:0] COOKIE_B2 = 8'd83;
  localparam logic [7:0] COOKIE_B3 = 8'd99;

  // Option codes
  localparam logic [7:0] OPT_PAD         = 8'd0;
  localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
  localparam logic [7:0] OPT_ROUTERS     = 8'd3;
  localparam logic [7:0] OPT_DNS_SERVERS = 8'd6;
  localparam logic [7:0] OPT_DOMAIN_NAME = 8'd15;
  localparam logic [7:0] OPT_LEASE_TIME  = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
  localparam logic [7:0] OPT_END         = 8'd255;

  // Minimum option lengths
  localparam logic [7:0] LEN_MSGTYPE = 8'd1;
  localparam logic [7:0] LEN_ADDR    = 8'd4;

  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    K_MSGTYPE   = 4'd0,
    K_SERVER    = 4'd1,
    K_LEASE     = 4'd2,
    K_MASK      = 4'd3,
    K_ROUTER    = 4'd4,
    K_DNS       = 4'd5,
    K_DOMAIN    = 4'd6,
    K_DONE      = 4'd7,
    K_BADCOOKIE = 4'd8,
    K_MALFORMED = 4'd9
  } kind_e;

  // One queued result; close_after asks for a trailing malformed close
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [5:0]  list_index;
    logic        last;
    logic        close_after;
  } entry_t;

  // Expected cookie byte at a given position
  function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = COOKIE_B0;
      2'd1:    b = COOKIE_B1;
      2'd2:    b = COOKIE_B2;
      default: b = COOKIE_B3;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/dofe_parser.sv */
// Front end: accepts option bytes, walks the TLV structure, queues results.
module dofe_parser import dofe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_buffer_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     push_entry_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  cookie_pos_q, cookie_pos_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] gather_q, gather_d;
  logic [1:0]  count_q, count_d;
  logic [7:0]  index_q, index_d;

  logic   accept;
  logic   res_valid;
  logic   field_hit;
  entry_t res;
  logic   do_close;
  kind_e  close_kind;
  logic   full;
  logic [7:0] need;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Byte classification and result for the current beat
  always_comb begin
    field_hit  = 1'b0;
    res        = '{kind: K_DONE, value: '0, list_index: '0, last: 1'b0, close_after: 1'b0};
    do_close   = 1'b0;
    close_kind = K_MALFORMED;
    full       = (count_q == 2'd3);
    need       = '0;

    case (phase_q)
      PH_COOKIE: begin
        if (data_byte_i != cookie_byte(cookie_pos_q)) begin
          do_close   = 1'b1;
          close_kind = K_BADCOOKIE;
        end else begin
          do_close = end_of_buffer_i;
        end
      end
      PH_CODE: begin
        if (data_byte_i == OPT_END) begin
          do_close   = 1'b1;
          close_kind = K_DONE;
        end else begin
          do_close = end_of_buffer_i;
        end
      end
      PH_LEN: begin
        if (code_q == OPT_MSG_TYPE) begin
          need = LEN_MSGTYPE;
        end else if (code_q == OPT_SERVER_ID ||
                     code_q == OPT_LEASE_TIME || code_q == OPT_SUBNET_MASK) begin
          need = LEN_ADDR;
        end
        do_close = (data_byte_i < need) || end_of_buffer_i;
      end
      PH_DATA: begin
        case (code_q)
          OPT_MSG_TYPE: begin
            if (index_q == 8'd0) begin
              field_hit = 1'b1;
              res.kind  = K_MSGTYPE;
              res.value = {24'd0, data_byte_i};
            end
          end
          OPT_SERVER_ID, OPT_LEASE_TIME, OPT_SUBNET_MASK: begin
            if (full && index_q == 8'd0) begin
              field_hit = 1'b1;
              res.kind  = (code_q == OPT_SERVER_ID) ? K_SERVER :
                          (code_q == OPT_LEASE_TIME) ? K_LEASE : K_MASK;
              res.value = {gather_q[23:0], data_byte_i};
            end
          end
          OPT_ROUTERS, OPT_DNS_SERVERS: begin
            if (full) begin
              field_hit      = 1'b1;
              res.kind       = (code_q == OPT_ROUTERS) ? K_ROUTER : K_DNS;
              res.value      = {gather_q[23:0], data_byte_i};
              res.list_index = index_q[5:0];
            end
          end
          OPT_DOMAIN_NAME: begin
            field_hit      = 1'b1;
            res.kind       = K_DOMAIN;
            res.value      = {24'd0, data_byte_i};
            res.list_index = index_q[5:0];
          end
          default: ;
        endcase
        do_close = end_of_buffer_i;
      end
      default: ;
    endcase

    // Closing result ends the area
    res_valid = field_hit || do_close;
    if (do_close) begin
      if (field_hit) begin
        res.close_after = 1'b1;
      end else begin
        res = '{kind: close_kind, value: '0, list_index: '0, last: 1'b1, close_after: 1'b0};
      end
    end
  end

  // Next walk state
  always_comb begin
    phase_d      = phase_q;
    cookie_pos_d = cookie_pos_q;
    code_d       = code_q;
    left_d       = left_q;
    gather_d     = gather_q;
    count_d      = count_q;
    index_d      = index_q;

    case (phase_q)
      PH_COOKIE: begin
        if (data_byte_i == cookie_byte(cookie_pos_q)) begin
          if (cookie_pos_q == 2'd3) begin
            cookie_pos_d = '0;
            phase_d      = PH_CODE;
          end else begin
            cookie_pos_d = cookie_pos_q + 2'd1;
          end
        end
      end
      PH_CODE: begin
        if (data_byte_i != OPT_END && data_byte_i != OPT_PAD) begin
          code_d  = data_byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (data_byte_i >= need) begin
          left_d   = data_byte_i;
          gather_d = '0;
          count_d  = '0;
          index_d  = '0;
          phase_d  = (data_byte_i != 8'd0) ? PH_DATA : PH_CODE;
        end
      end
      PH_DATA: begin
        gather_d = {gather_q[23:0], data_byte_i};
        count_d  = count_q + 2'd1;
        if (field_hit) begin
          index_d = index_q + 8'd1;
        end
        left_d = left_q - 8'd1;
        if (left_q == 8'd1) begin
          code_d   = '0;
          left_d   = '0;
          gather_d = '0;
          count_d  = '0;
          index_d  = '0;
          phase_d  = PH_CODE;
        end
      end
      default: begin
        // Skipping until the end of the buffer
        if (end_of_buffer_i) begin
          code_d       = '0;
          left_d       = '0;
          gather_d     = '0;
          count_d      = '0;
          index_d      = '0;
          cookie_pos_d = '0;
          phase_d      = PH_COOKIE;
        end
      end
    endcase

    // A close clears the option and waits for the next area
    if (do_close) begin
      code_d       = '0;
      left_d       = '0;
      gather_d     = '0;
      count_d      = '0;
      index_d      = '0;
      cookie_pos_d = '0;
      phase_d      = end_of_buffer_i ? PH_COOKIE : PH_SKIP;
    end
  end

  assign push_o       = accept && res_valid;
  assign push_entry_o = res;

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_COOKIE;
      cookie_pos_q <= '0;
      code_q       <= '0;
      left_q       <= '0;
      gather_q     <= '0;
      count_q      <= '0;
      index_q      <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      cookie_pos_q <= cookie_pos_d;
      code_q       <= code_d;
      left_q       <= left_d;
      gather_q     <= gather_d;
      count_q      <= count_d;
      index_q      <= index_d;
    end
  end

endmodule

/* hw/rtl/dofe_queue.sv */
// Small register FIFO between the parser and the result emitter.
module dofe_queue import dofe_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   not_empty_o,
  output entry_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  entry_t        mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/dofe_emitter.sv */
// Back end: output register that drains the queue, one result beat per cycle while the output is not stalled.
module dofe_emitter import dofe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        not_empty_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [31:0] value_o,
  output logic [5:0]  list_index_o,
  output logic        last_o
);

  logic        valid_q;
  logic        pend_q;
  kind_e       kind_q;
  logic [31:0] value_q;
  logic [5:0]  index_q;
  logic        last_q;
  logic        load;

  // Output register free or being taken this cycle
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && not_empty_i;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= not_empty_i;
        pend_q  <= not_empty_i && head_i.close_after;
      end
    end
  end

  // Payload; a pending close goes out as a malformed beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        kind_q  <= K_MALFORMED;
        value_q <= '0;
        index_q <= '0;
        last_q  <= 1'b1;
      end else if (not_empty_i) begin
        kind_q  <= head_i.kind;
        value_q <= head_i.value;
        index_q <= head_i.list_index;
        last_q  <= head_i.last;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign list_index_o = index_q;
  assign last_o       = last_q;

endmodule

/* hw/rtl/dhcp_option_field_extractor_core.sv */
// A result beat passes from the parser through the result queue and the output register before it is presented.
// Throughput: one byte per cycle while the result queue is not full; a byte ending a truncated area after a data
// result gives two beats, the data result and then a malformed close, which the output register sends in turn.
// The parser stalls only while the result queue is full.
// Reset (async, active low) clears the parser to the cookie check and empties queue and output.
module dhcp_option_field_extractor_core import dofe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [31:0] value_o,
  output logic [5:0]  list_index_o,
  output logic        last_o
);

  logic   q_full, q_push, q_pop, q_not_empty;
  entry_t q_push_entry, q_head;

  // Front: byte walk
  dofe_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .push_entry_o    (q_push_entry)
  );

  // Decoupling queue
  dofe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .not_empty_o  (q_not_empty),
    .head_o       (q_head)
  );

  // Back: result beats
  dofe_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .not_empty_i  (q_not_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .list_index_o (list_index_o),
    .last_o       (last_o)
  );

endmodule

/* dv/dofe_checker.sv */
// Scoreboard for the DHCP options field extractor: mirrors the parser and checks result beats.
module dofe_checker import dofe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  list_index_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [31:0] MAGIC = {COOKIE_B0, COOKIE_B1, COOKIE_B2, COOKIE_B3};

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [5:0]  list_index;
    logic        last;
  } field_beat_t;

  // Result beats owed by the block, oldest first
  field_beat_t expected_fields_q[$];
  field_beat_t oldest;

  // Mirror of the parser state
  phase_e      ph;
  logic [1:0]  cookie_pos;
  logic [7:0]  opt_code;
  logic [7:0]  opt_left;
  logic [31:0] gather;
  logic [1:0]  gathered;
  logic [7:0]  entry_idx;

  task automatic owe_field(input kind_e kind, input logic [31:0] value,
                           input logic [5:0] idx, input logic last);
    field_beat_t beat;
    beat.kind       = kind;
    beat.value      = value;
    beat.list_index = idx;
    beat.last       = last;
    expected_fields_q.push_back(beat);
  endtask

  task automatic clear_option();
    opt_code  = OPT_PAD;
    opt_left  = 8'd0;
    gather    = 32'd0;
    gathered  = 2'd0;
    entry_idx = 8'd0;
  endtask

  // Closing beat; without end of buffer the rest of the area is skipped
  task automatic close_area(input kind_e kind, input logic eob);
    owe_field(kind, 32'd0, 6'd0, 1'b1);
    clear_option();
    cookie_pos = 2'd0;
    ph = eob ? PH_COOKIE : PH_SKIP;
  endtask

  // Works out the result beats caused by one accepted options byte
  task automatic predict_fields(input logic [7:0] b, input logic eob);
    logic [7:0] need;
    logic       full;
    kind_e      addr_kind;
    case (ph)
      PH_COOKIE: begin
        if (b != MAGIC[8*(3-int'(cookie_pos)) +: 8]) begin
          close_area(K_BADCOOKIE, eob);
        end else begin
          if (cookie_pos == 2'd3) ph = PH_CODE;
          cookie_pos = cookie_pos + 2'd1;
          if (eob) close_area(K_MALFORMED, eob);
        end
      end
      PH_CODE: begin
        if (b == OPT_END) begin
          close_area(K_DONE, eob);
        end else begin
          if (b != OPT_PAD) begin
            opt_code = b;
            ph = PH_LEN;
          end
          if (eob) close_area(K_MALFORMED, eob);
        end
      end
      PH_LEN: begin
        need = 8'd0;
        if (opt_code == OPT_MSG_TYPE) begin
          need = LEN_MSGTYPE;
        end else if (opt_code == OPT_SERVER_ID ||
                     opt_code == OPT_LEASE_TIME || opt_code == OPT_SUBNET_MASK) begin
          need = LEN_ADDR;
        end
        if (b < need) begin
          close_area(K_MALFORMED, eob);
        end else begin
          opt_left  = b;
          gather    = 32'd0;
          gathered  = 2'd0;
          entry_idx = 8'd0;
          ph = (b != 8'd0) ? PH_DATA : PH_CODE;
          if (eob) close_area(K_MALFORMED, eob);
        end
      end
      PH_DATA: begin
        // value bytes gather first-most-significant, four to a word
        gather   = {gather[23:0], b};
        full     = (gathered == 2'd3);
        gathered = gathered + 2'd1;
        case (opt_code)
          OPT_MSG_TYPE: begin
            if (entry_idx == 8'd0) begin
              owe_field(K_MSGTYPE, {24'd0, b}, 6'd0, 1'b0);
              entry_idx = 8'd1;
            end
          end
          OPT_SERVER_ID, OPT_LEASE_TIME, OPT_SUBNET_MASK: begin
            if (full && entry_idx == 8'd0) begin
              addr_kind = (opt_code == OPT_SERVER_ID) ? K_SERVER :
                          (opt_code == OPT_LEASE_TIME) ? K_LEASE : K_MASK;
              owe_field(addr_kind, gather, 6'd0, 1'b0);
              entry_idx = 8'd1;
            end
          end
          OPT_ROUTERS, OPT_DNS_SERVERS: begin
            if (full) begin
              addr_kind = (opt_code == OPT_ROUTERS) ? K_ROUTER : K_DNS;
              owe_field(addr_kind, gather, entry_idx[5:0], 1'b0);
              entry_idx = entry_idx + 8'd1;
            end
          end
          OPT_DOMAIN_NAME: begin
            owe_field(K_DOMAIN, {24'd0, b}, entry_idx[5:0], 1'b0);
            entry_idx = entry_idx + 8'd1;
          end
          default: ;
        endcase
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) begin
          clear_option();
          ph = PH_CODE;
        end
        if (eob) close_area(K_MALFORMED, eob);
      end
      default: begin
        // after a close, wait for the end of the buffer
        if (eob) begin
          clear_option();
          cookie_pos = 2'd0;
          ph = PH_COOKIE;
        end
      end
    endcase
  endtask

  // Result beat is checked before the byte beat of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_fields_q.delete();
      clear_option();
      cookie_pos   = 2'd0;
      ph           = PH_COOKIE;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_fields_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: stray result beat: expected none, got kind %0d value %h index %0d last %b",
                   $time, kind_i, value_i, list_index_i, last_i);
        end else begin
          oldest = expected_fields_q.pop_front();
          if (kind_i != oldest.kind || value_i != oldest.value ||
              list_index_i != oldest.list_index || last_i != oldest.last) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: result mismatch: expected %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                     $time, oldest.kind, oldest.value, oldest.list_index, oldest.last,
                     kind_i, value_i, list_index_i, last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_fields(data_byte_i, end_of_buffer_i);
      pending_o = expected_fields_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the DHCP options field extractor: clock, reset, byte stimulus and verdict.
module tb_top;
  import dofe_pkg::*;

  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [3:0]  kind_o;
  logic [31:0] value_o;
  logic [5:0]  list_index_o;
  logic        last_o;

  int fail_count;
  int pending;
  int cycles     = 0;
  int sent       = 0;
  int tail_bytes = 0;
  logic calm     = 1'b0;
  logic paused   = 1'b0;

  // Bytes of the area being sent: {end_of_buffer, data}
  logic [8:0] area_q[$];

  dhcp_option_field_extractor_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .list_index_o    (list_index_o),
    .last_o          (last_o)
  );

  dofe_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .value_i         (value_o),
    .list_index_i    (list_index_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side stalls at random, except in the calm stretch
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 31);
  end

  task automatic push_b(input logic [7:0] b);
    area_q.push_back({1'b0, b});
  endtask

  // Bytes the parser ignores after a close
  task automatic push_tail(input int n);
    repeat (n) area_q.push_back({1'b0, 8'($urandom)});
    tail_bytes = tail_bytes + n;
  endtask

  task automatic push_cookie();
    push_b(COOKIE_B0);
    push_b(COOKIE_B1);
    push_b(COOKIE_B2);
    push_b(COOKIE_B3);
  endtask

  task automatic push_option(input logic [7:0] code, input int len);
    push_b(code);
    push_b(8'(len));
    repeat (len) push_b(8'($urandom));
  endtask

  task automatic mark_end();
    logic [8:0] beat;
    beat = area_q.pop_back();
    beat[8] = 1'b1;
    area_q.push_back(beat);
  endtask

  // One option, mostly of a sensible length for its code
  task automatic push_random_option();
    int         pick;
    int         len;
    logic [7:0] code;
    pick = $urandom_range(0, 9);
    case (pick)
      0: push_b(OPT_PAD);
      1: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        push_option(OPT_MSG_TYPE, len);
      end
      2, 3, 4: begin
        code = (pick == 2) ? OPT_SERVER_ID :
               (pick == 3) ? OPT_LEASE_TIME : OPT_SUBNET_MASK;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : 4;
        push_option(code, len);
      end
      5, 6: begin
        code = (pick == 5) ? OPT_ROUTERS : OPT_DNS_SERVERS;
        // rarely a long list of 60 to 63 addresses, reaching list index 62
        len = ($urandom_range(0, 39) == 0) ? 4 * $urandom_range(60, 63) :
              4 * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) len = len + $urandom_range(1, 3);
        push_option(code, len);
      end
      7: begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 100) : $urandom_range(1, 12);
        push_option(OPT_DOMAIN_NAME, len);
      end
      8: push_option(8'($urandom_range(2, 254)), $urandom_range(0, 8));
      default: begin
        code = ($urandom_range(0, 1) == 0) ? OPT_ROUTERS : OPT_DOMAIN_NAME;
        push_option(code, 0);
      end
    endcase
  endtask

  // One options area: mostly well formed, the rest cut short, bad or noise
  task automatic push_random_area();
    int         mode;
    int         cut;
    int         pos;
    logic [7:0] code;
    mode = $urandom_range(0, 99);
    if (mode < 80) begin
      push_cookie();
      repeat ($urandom_range(0, 6)) push_random_option();
      push_b(OPT_END);
      if (mode >= 68) begin
        // truncated: end of buffer lands somewhere before End
        cut = $urandom_range(1, area_q.size() - 1);
        while (area_q.size() > cut) void'(area_q.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        push_tail($urandom_range(1, 3));
      end
    end else if (mode < 88) begin
      pos = $urandom_range(0, 3);
      push_cookie();
      while (area_q.size() > pos + 1) void'(area_q.pop_back());
      push_b(8'(area_q.pop_back()) ^ 8'($urandom_range(1, 255)));
      push_tail($urandom_range(0, 4));
    end else if (mode < 94) begin
      push_cookie();
      if ($urandom_range(0, 1) == 0) push_random_option();
      case ($urandom_range(0, 3))
        0:       code = OPT_MSG_TYPE;
        1:       code = OPT_SERVER_ID;
        2:       code = OPT_LEASE_TIME;
        default: code = OPT_SUBNET_MASK;
      endcase
      push_b(code);
      push_b((code == OPT_MSG_TYPE) ? 8'd0 : 8'($urandom_range(0, 3)));
      push_tail($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 8)) push_b(8'($urandom));
    end
    mark_end();
  endtask

  // Sends the queued area; each cycle before a beat may idle at random
  task automatic send_area();
    logic [8:0] beat;
    while (area_q.size() != 0) begin
      beat = area_q.pop_front();
      @(negedge clk_i);
      while (!calm && $urandom_range(0, 99) < 31) begin
        in_valid_i      = 1'b0;
        data_byte_i     = 8'($urandom);
        end_of_buffer_i = 1'($urandom);
        @(negedge clk_i);
      end
      in_valid_i      = 1'b1;
      data_byte_i     = beat[7:0];
      end_of_buffer_i = beat[8];
      do @(posedge clk_i); while (in_stall_o);
      sent = sent + 1;
    end
  endtask

  // Holds the byte side off until every owed result beat has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: pad, extreme message type and lease, router with a partial group,
    // one domain byte, End with end of buffer
    push_cookie();
    push_b(OPT_PAD);
    push_b(OPT_MSG_TYPE); push_b(8'd1); push_b(8'hFF);
    push_b(OPT_LEASE_TIME); push_b(8'd4);
    push_b(8'hFF); push_b(8'hFF); push_b(8'hFF); push_b(8'hFF);
    push_b(OPT_ROUTERS); push_b(8'd5);
    push_b(8'h00); push_b(8'h80); push_b(8'h01); push_b(8'hFE); push_b(8'h7F);
    push_b(OPT_DOMAIN_NAME); push_b(8'd1); push_b(8'h41);
    push_b(OPT_END);
    mark_end();
    // bad cookie on the very first byte, with end of buffer
    push_b(8'h00);
    mark_end();
    // short subnet mask; end of buffer on the length byte
    push_cookie();
    push_b(OPT_SUBNET_MASK); push_b(8'd3);
    mark_end();
    send_area();
    drain_results();

    // Random areas; a calm stretch with no idling, and one full drain midway
    while (sent - tail_bytes < RANDOM_BYTES) begin
      calm = (sent >= 700 && sent < 1000);
      if (!paused && sent >= 1200) begin
        drain_results();
        paused = 1'b1;
      end
      push_random_area();
      send_area();
    end
    calm = 1'b0;
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dofe_pkg.sv
hw/rtl/dofe_parser.sv
hw/rtl/dofe_queue.sv
hw/rtl/dofe_emitter.sv
hw/rtl/dhcp_option_field_extractor_core.sv
dv/dofe_checker.sv
dv/tb_top.sv
